// ----- rtl/plr_pkg.sv -----
// Package for the process load ranker: command types, codes and constants.
// Used by plr_front, plr_back, plr_div and the top level; no dependencies.
package plr_pkg;

  localparam int LIST_DEPTH_DEF = 7;
  localparam int PID_SLOTS_DEF  = 4096;
  localparam int QUEUE_DEPTH    = 2;

  // Load scale: percent (100) in Q8 (256).
  localparam int PCT_SCALE  = 100;
  localparam int Q8_ONE     = 256;
  localparam int LOAD_SCALE = PCT_SCALE * Q8_ONE;
  localparam int SCALE_W    = 15;
  localparam int NUMER_W    = 32 + SCALE_W;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_EMIT   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_START,
    OP_SAMPLE,
    OP_EMIT
  } op_t;

  // One classified item. data holds the period on a start and the
  // tick total on a sample.
  typedef struct packed {
    op_t         op;
    logic [11:0] pid;
    logic [31:0] data;
  } cmd_t;

endpackage

// ----- rtl/plr_front.sv -----
// Front end of the ranker: accepts items, classifies them and queues them.
// Depends on plr_pkg.
module plr_front import plr_pkg::*; #(
  parameter int PID_SLOTS = PID_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] period_ticks,
  input  logic [11:0] pid,
  input  logic [31:0] total_ticks,
  input  logic        hold,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             keep;
  logic             push;
  cmd_t             cmd;

  assign in_stall = hold || (count == CNT_W'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  // Classify; unused kinds and samples with out-of-range pids are dropped here.
  always_comb begin
    cmd.pid  = pid;
    cmd.data = total_ticks;
    cmd.op   = OP_SAMPLE;
    keep     = 1'b0;
    unique case (kind)
      KIND_START: begin
        cmd.op   = OP_START;
        cmd.data = period_ticks;
        keep     = 1'b1;
      end
      KIND_SAMPLE: begin
        keep = (32'(pid) < 32'(PID_SLOTS));
      end
      KIND_EMIT: begin
        cmd.op = OP_EMIT;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push    = accept && keep;
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(q_pop);
    end
  end

endmodule

// ----- rtl/plr_div.sv -----
// Restoring divider, one quotient bit per cycle, for the load percentage.
// Quotient is known to fit in 32 bits. Depends on plr_pkg.
module plr_div import plr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUMER_W-1:0] numer,
  input  logic [31:0]        denom,
  output logic               done,
  output logic [31:0]        quot
);

  logic        busy;
  logic [5:0]  steps;
  logic [32:0] rem;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [31:0] den;

  assign rem_sh = {rem[31:0], quot[31]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= 33'(numer[NUMER_W-1:32]);
      quot <= numer[31:0];
      den  <= denom;
    end else if (busy) begin
      if (!diff[32]) begin
        rem  <= diff;
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/plr_back.sv -----
// Back end of the ranker: tick memory, ranked list, and the emit sequencer.
// Depends on plr_pkg and plr_div.
module plr_back import plr_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int PID_SLOTS  = PID_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  rank,
  output logic [11:0] entry_pid,
  output logic [31:0] delta_ticks,
  output logic [31:0] load_pct_q8,
  output logic        last
);

  localparam int ADDR_W = $clog2(PID_SLOTS);
  localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_UPD, S_INS, S_MUL, S_CHK, S_DIV, S_OUT
  } state_t;

  state_t              state;
  logic [31:0]         mem [PID_SLOTS];
  logic [31:0]         rd_data;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   addr;
  logic [11:0]         cur_pid;
  logic [31:0]         cur_total;
  logic [31:0]         delta;
  logic [31:0]         scan_period;
  logic [11:0]         ranked_pid   [LIST_DEPTH];
  logic [31:0]         ranked_delta [LIST_DEPTH];
  logic [11:0]         pid_next     [LIST_DEPTH];
  logic [31:0]         delta_next   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] gt;
  logic [IDX_W-1:0]    idx;
  logic [NUMER_W-1:0]  numer;
  logic                div_start;
  logic                div_done;
  logic [31:0]         div_quot;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [31:0]         mem_wdata;

  assign clearing = (state == S_CLR);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign addr     = ADDR_W'(q_pop ? q_cmd.pid : cur_pid);

  assign mem_we    = clearing || (state == S_UPD);
  assign mem_waddr = clearing ? clr_addr : ADDR_W'(cur_pid);
  assign mem_wdata = clearing ? 32'd0 : cur_total;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[addr];
  end

  // The list stays in descending order, so gt is a thermometer code and
  // each entry picks its old value, its upper neighbor or the new delta.
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      gt[i] = (delta > ranked_delta[i]);
    end
    for (int j = 0; j < LIST_DEPTH; j++) begin
      if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
        pid_next[j]   = ranked_pid[(j > 0) ? j - 1 : 0];
        delta_next[j] = ranked_delta[(j > 0) ? j - 1 : 0];
      end else if (gt[j]) begin
        pid_next[j]   = cur_pid;
        delta_next[j] = delta;
      end else begin
        pid_next[j]   = ranked_pid[j];
        delta_next[j] = ranked_delta[j];
      end
    end
  end

  assign div_start = (state == S_CHK) && (delta_ticks != '0) && (scan_period != '0) &&
                     (numer[NUMER_W-1:32] < 15'(scan_period) || scan_period[31:15] != '0);

  plr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (scan_period),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      scan_period <= '0;
      idx         <= '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
        ranked_pid[i]   <= '0;
        ranked_delta[i] <= '0;
      end
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(PID_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_pid   <= q_cmd.pid;
            cur_total <= q_cmd.data;
            unique case (q_cmd.op)
              OP_START: begin
                scan_period <= q_cmd.data;
                for (int i = 0; i < LIST_DEPTH; i++) begin
                  ranked_pid[i]   <= '0;
                  ranked_delta[i] <= '0;
                end
              end
              OP_SAMPLE: state <= S_UPD;
              OP_EMIT: begin
                idx   <= '0;
                state <= S_MUL;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_UPD: begin
          delta <= cur_total - rd_data;
          state <= S_INS;
        end
        S_INS: begin
          if (delta != '0) begin
            ranked_pid   <= pid_next;
            ranked_delta <= delta_next;
          end
          state <= S_IDLE;
        end
        S_MUL: begin
          numer       <= NUMER_W'(ranked_delta[idx]) * NUMER_W'(LOAD_SCALE);
          rank        <= 3'(idx);
          entry_pid   <= ranked_pid[idx];
          delta_ticks <= ranked_delta[idx];
          last        <= (idx == IDX_W'(LIST_DEPTH - 1));
          state       <= S_CHK;
        end
        S_CHK: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            load_pct_q8 <= (delta_ticks == '0) ? 32'd0 : 32'hFFFF_FFFF;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            load_pct_q8 <= div_quot;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result shown outside the output state");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result after the last entry");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE))
    else $error("queue popped while busy");
  a_list_order: assert property (@(posedge clk) disable iff (rst)
    ranked_delta[0] >= ranked_delta[LIST_DEPTH-1])
    else $error("ranked list out of order");
`endif

endmodule

// ----- rtl/process_load_top_k_ranker_core.sv -----
// Top level of the process load ranker: front end, queue and back end.
// Depends on plr_pkg, plr_front and plr_back.
//
//   channel | signals                               | direction
//   input   | in_valid, in_stall, kind, period_ticks, | in
//           | pid, total_ticks                       |
//   output  | out_valid, out_stall, rank, entry_pid, | out
//           | delta_ticks, load_pct_q8, last         |
//
// After reset the tick memory is cleared one entry a cycle, with in_stall
// held high. A start item is handled in the back end's idle state alone, a
// sample in steps (memory read, update with write-back, list insert). An end
// item yields LIST_DEPTH results; each passes through multiply, check, the
// one-bit-a-cycle divider unless the load is zero or saturates, and output,
// where it waits on out_stall.
// The two-entry queue takes up to two items while the back end works or stalls.
module process_load_top_k_ranker_core import plr_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int PID_SLOTS  = PID_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] period_ticks,
  input  logic [11:0] pid,
  input  logic [31:0] total_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  rank,
  output logic [11:0] entry_pid,
  output logic [31:0] delta_ticks,
  output logic [31:0] load_pct_q8,
  output logic        last
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic clearing;

  // Front end classifies and queues; it holds off while memory clears.
  plr_front #(.PID_SLOTS(PID_SLOTS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .period_ticks (period_ticks),
    .pid          (pid),
    .total_ticks  (total_ticks),
    .hold         (clearing),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  // Back end runs one command at a time and owns all ranker state.
  plr_back #(.LIST_DEPTH(LIST_DEPTH), .PID_SLOTS(PID_SLOTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rank        (rank),
    .entry_pid   (entry_pid),
    .delta_ticks (delta_ticks),
    .load_pct_q8 (load_pct_q8),
    .last        (last)
  );

endmodule
